// ===== src/pfc_pkg.sv =====
package pfc_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENTRY_W = 216;

  localparam logic [15:0] ET_VLAN_Q = 16'h8100;
  localparam logic [15:0] ET_VLAN_AD = 16'h88A8;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [6:0] POS_MAX = 7'd127;
  localparam logic [31:0] MASK_RESET = 32'hFFFF0000;
  localparam logic [31:0] BASE_RESET = 32'h0A640000;

  localparam logic REG_MASK = 1'b0;
  localparam logic REG_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_EXIST = 3'd0,
    ST_NEW = 3'd1,
    ST_FULL = 3'd2,
    ST_NOT_IP = 3'd3,
    ST_BAD = 3'd4
  } status_t;

  typedef struct packed {
    logic take;
    logic mask;
    logic search_start;
    logic rd;
    logic next;
    logic hit;
    logic insert;
    logic full;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    status_t code;
    logic at_end;
    logic room;
    logic match;
    logic out_free;
  } stat_t;

endpackage

// ===== src/pfc_in_if.sv =====
interface pfc_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;
  logic [15:0] frame_length;
  logic direction;

  modport source (output valid, data_byte, last_byte, frame_length, direction, input ready);
  modport sink (input valid, data_byte, last_byte, frame_length, direction, output ready);
endinterface

// ===== src/pfc_out_if.sv =====
interface pfc_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [15:0] ether_type;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0] ip_protocol;
  logic [63:0] packet_count;
  logic [63:0] byte_count;

  modport source (output valid, status, ether_type, source_address, dest_address,
                  ip_protocol, packet_count, byte_count, input ready);
  modport sink (input valid, status, ether_type, source_address, dest_address,
                ip_protocol, packet_count, byte_count, output ready);
endinterface

// ===== src/pfc_ctrl.sv =====
module pfc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  pfc_pkg::stat_t stat,
  output pfc_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_READ   = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_HIT    = 7'b0010000,
    S_INSERT = 7'b0100000,
    S_FULL   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.code != pfc_pkg::ST_EXIST) begin
          if (stat.out_free) begin
            cmd.emit_err = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.mask = 1'b1;
          cmd.search_start = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.at_end) begin
          state_next = stat.room ? S_INSERT : S_FULL;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          state_next = S_HIT;
        end else begin
          cmd.next = 1'b1;
          state_next = S_READ;
        end
      end
      S_HIT: begin
        if (stat.out_free) begin
          cmd.hit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INSERT: begin
        if (stat.out_free) begin
          cmd.insert = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FULL: begin
        if (stat.out_free) begin
          cmd.full = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/pfc_datapath.sv =====
module pfc_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] data_byte,
  input  logic [15:0] frame_length,
  input  logic direction,
  input  logic in_last,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  pfc_pkg::cmd_t cmd,
  output pfc_pkg::stat_t stat,
  pfc_out_if.source out_ch
);

  logic [31:0] net_mask;
  logic [31:0] net_base;

  logic [6:0] pos;
  logic [15:0] et;
  logic [3:0] hw;
  logic [7:0] prot;
  logic [31:0] src;
  logic [31:0] dst;
  logic has_vlan;
  logic [15:0] flen;
  logic dir;

  logic [pfc_pkg::CNT_W-1:0] used [2];
  logic [pfc_pkg::CNT_W-1:0] idx;

  logic [pfc_pkg::ENTRY_W-1:0] mem [2*pfc_pkg::TABLE_ENTRIES];
  logic [pfc_pkg::ENTRY_W-1:0] rdata;

  logic out_valid;
  logic [2:0] out_status;
  logic [15:0] out_et;
  logic [31:0] out_src;
  logic [31:0] out_dst;
  logic [7:0] out_prot;
  logic [63:0] out_pk;
  logic [63:0] out_by;

  logic [7:0] l3;
  logic [7:0] cnt;
  logic [6:0] ofs;
  logic [15:0] et_shift;
  logic [87:0] key;
  logic [63:0] hit_pk;
  logic [63:0] hit_by;
  logic [pfc_pkg::ADDR_W-1:0] rd_addr;
  logic [pfc_pkg::ADDR_W-1:0] ins_addr;
  logic emit;

  assign l3 = has_vlan ? 8'd18 : 8'd14;
  assign cnt = {1'b0, pos};
  assign ofs = pos - l3[6:0];
  assign et_shift = {et[7:0], data_byte};
  assign key = {src, dst, et, prot};
  assign hit_pk = rdata[127:64] + 64'd1;
  assign hit_by = rdata[63:0] + {48'd0, flen};
  assign rd_addr = {dir, idx[pfc_pkg::IDX_W-1:0]};
  assign ins_addr = {dir, used[dir][pfc_pkg::IDX_W-1:0]};
  assign emit = cmd.emit_err | cmd.hit | cmd.insert | cmd.full;

  always_comb begin
    stat.code = pfc_pkg::ST_EXIST;
    if (cnt < 8'd14 || cnt < l3) begin
      stat.code = pfc_pkg::ST_BAD;
    end else if (et == pfc_pkg::ET_IPV4) begin
      if (cnt < l3 + 8'd20 || hw < 4'd5 || cnt < l3 + {2'b0, hw, 2'b0}) begin
        stat.code = pfc_pkg::ST_BAD;
      end
    end else if (et == pfc_pkg::ET_IPV6) begin
      if (cnt < l3 + 8'd40) stat.code = pfc_pkg::ST_BAD;
    end else begin
      stat.code = pfc_pkg::ST_NOT_IP;
    end
    stat.at_end = (idx == used[dir]);
    stat.room = (used[dir] != pfc_pkg::CNT_W'(pfc_pkg::TABLE_ENTRIES));
    stat.match = (rdata[215:128] == key);
    stat.out_free = !out_valid || out_ch.ready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      net_mask <= pfc_pkg::MASK_RESET;
      net_base <= pfc_pkg::BASE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pfc_pkg::REG_MASK) net_mask <= cfg_data;
      else net_base <= cfg_data;
    end
  end

  // header parsing
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      pos <= '0;
      et <= '0;
      hw <= '0;
      prot <= '0;
      src <= '0;
      dst <= '0;
      has_vlan <= 1'b0;
    end else if (cmd.take) begin
      if (pos < pfc_pkg::POS_MAX) begin
        pos <= pos + 7'd1;
        if (pos == 7'd12 || pos == 7'd13 || (has_vlan && (pos == 7'd16 || pos == 7'd17))) begin
          et <= et_shift;
          if (pos == 7'd13) begin
            has_vlan <= (et_shift == pfc_pkg::ET_VLAN_Q) || (et_shift == pfc_pkg::ET_VLAN_AD);
          end
        end else if ({1'b0, pos} >= l3) begin
          if (et == pfc_pkg::ET_IPV4) begin
            if (ofs == 7'd0) hw <= data_byte[3:0];
            else if (ofs == 7'd9) prot <= data_byte;
            else if (ofs >= 7'd12 && ofs <= 7'd15) src <= {src[23:0], data_byte};
            else if (ofs >= 7'd16 && ofs <= 7'd19) dst <= {dst[23:0], data_byte};
          end else if (et == pfc_pkg::ET_IPV6 && ofs == 7'd6) begin
            prot <= data_byte;
          end
        end
      end
    end else if (cmd.mask) begin
      if (et == pfc_pkg::ET_IPV6 || (src & net_mask) != net_base) src <= '0;
      if (et == pfc_pkg::ET_IPV6 || (dst & net_mask) != net_base) dst <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_last) begin
      flen <= frame_length;
      dir <= direction;
    end
  end

  // table search
  always_ff @(posedge clk) begin
    if (rst) begin
      used[0] <= '0;
      used[1] <= '0;
      idx <= '0;
    end else begin
      if (cmd.search_start) idx <= '0;
      else if (cmd.next) idx <= idx + pfc_pkg::CNT_W'(1);
      if (cmd.insert) used[dir] <= used[dir] + pfc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[rd_addr];
    if (cmd.hit) mem[rd_addr] <= {rdata[215:128], hit_pk, hit_by};
    else if (cmd.insert) mem[ins_addr] <= {key, 64'd1, {48'd0, flen}};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_et <= et;
      out_src <= src;
      out_dst <= dst;
      out_prot <= prot;
      out_pk <= '0;
      out_by <= '0;
      if (cmd.emit_err) begin
        out_status <= stat.code;
        out_src <= '0;
        out_dst <= '0;
        out_prot <= '0;
        if (stat.code == pfc_pkg::ST_BAD) out_et <= '0;
      end else if (cmd.hit) begin
        out_status <= pfc_pkg::ST_EXIST;
        out_pk <= hit_pk;
        out_by <= hit_by;
      end else if (cmd.insert) begin
        out_status <= pfc_pkg::ST_NEW;
        out_pk <= 64'd1;
        out_by <= {48'd0, flen};
      end else begin
        out_status <= pfc_pkg::ST_FULL;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.ether_type = out_et;
  assign out_ch.source_address = out_src;
  assign out_ch.dest_address = out_dst;
  assign out_ch.ip_protocol = out_prot;
  assign out_ch.packet_count = out_pk;
  assign out_ch.byte_count = out_by;

endmodule

// ===== src/packet_flow_counter.sv =====
// packet flow counter
// in_ch carries one frame byte per transaction with last_byte, frame_length
// and direction; frame_length and direction are taken on the last byte.
// out_ch carries one result per frame: status, flow key and the counters.
// cfg_we/cfg_index/cfg_data write the subnet mask (0) and subnet base (1).
// bytes are taken one per cycle while a frame streams in. after the last
// byte the block stops taking bytes: a check state tests the header, then
// the flow table of the frame's direction is searched linearly through its
// single port memory, with a read state and a compare state per stored
// entry, and a final state updates the matching entry or inserts a new one
// (a full table is left as it is) and loads the result register. a frame
// that is not IP or has a bad header gets its result from the check state.
// reset clears the parser, both fill counts and the result valid bit; the
// tables need no clearing pass. a stalled receiver holds the result, and a
// following result waits until the register is free.
module packet_flow_counter (
  input  logic clk,
  input  logic rst,
  pfc_in_if.sink in_ch,
  pfc_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);

  pfc_pkg::cmd_t cmd;
  pfc_pkg::stat_t stat;

  pfc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_last(in_ch.last_byte),
    .in_ready(in_ch.ready),
    .stat(stat),
    .cmd(cmd)
  );

  pfc_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .data_byte(in_ch.data_byte),
    .frame_length(in_ch.frame_length),
    .direction(in_ch.direction),
    .in_last(in_ch.last_byte),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .stat(stat),
    .out_ch(out_ch)
  );

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    pfc_pkg::status_t status;
    logic [15:0] ether_type;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0] ip_protocol;
    logic [63:0] packet_count;
    logic [63:0] byte_count;
  } flow_result_t;

  typedef struct {
    logic [63:0] addrs;
    logic [23:0] prot;
    logic [63:0] pk;
    logic [63:0] by;
  } flow_entry_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;

  pfc_in_if in_ch ();
  pfc_out_if out_ch ();

  packet_flow_counter dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // own copy of block state
  logic [31:0] sub_mask;
  logic [31:0] sub_base;
  int p_pos;
  logic [15:0] p_et;
  logic [3:0] p_hw;
  logic [7:0] p_proto;
  logic [31:0] p_src;
  logic [31:0] p_dst;
  bit p_tag;
  flow_entry_t flows[2][$];

  flow_result_t expected_results[$];
  logic [7:0] frame_bytes[$];
  logic [31:0] addr_pool[6];

  int errors;
  int bytes_sent;
  int frames_sent;
  int results_seen;
  int status_seen[5];
  int quiet_cycles;
  bit idle_on;
  bit hold_req;
  int hold_left;
  bit finished;
  flow_result_t want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check(string name, logic [63:0] got, logic [63:0] exp);
    if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  task automatic clear_parser();
    p_pos = 0;
    p_et = '0;
    p_hw = '0;
    p_proto = '0;
    p_src = '0;
    p_dst = '0;
    p_tag = 0;
  endtask

  task automatic count_flow_byte(logic [7:0] b, logic last, logic [15:0] flen, logic dir);
    int l3;
    int o;
    int cnt;
    bit ok;
    bit found;
    flow_result_t r;
    flow_entry_t f;
    l3 = p_tag ? 18 : 14;
    if (p_pos < int'(pfc_pkg::POS_MAX)) begin
      if (p_pos == 12 || p_pos == 13 || (p_tag && (p_pos == 16 || p_pos == 17))) begin
        p_et = {p_et[7:0], b};
        if (p_pos == 13) p_tag = (p_et == pfc_pkg::ET_VLAN_Q || p_et == pfc_pkg::ET_VLAN_AD);
      end else if (p_pos >= l3) begin
        o = p_pos - l3;
        if (p_et == pfc_pkg::ET_IPV4) begin
          if (o == 0) p_hw = b[3:0];
          else if (o == 9) p_proto = b;
          else if (o >= 12 && o <= 15) p_src = {p_src[23:0], b};
          else if (o >= 16 && o <= 19) p_dst = {p_dst[23:0], b};
        end else if (p_et == pfc_pkg::ET_IPV6 && o == 6) begin
          p_proto = b;
        end
      end
      p_pos++;
    end
    if (!last) return;
    r = '{pfc_pkg::ST_NOT_IP, '0, '0, '0, '0, '0, '0};
    cnt = p_pos;
    l3 = p_tag ? 18 : 14;
    ok = 0;
    if (cnt < l3) begin
      r.status = pfc_pkg::ST_BAD;
    end else if (p_et == pfc_pkg::ET_IPV4) begin
      if (cnt < l3 + 20 || p_hw < 5 || cnt < l3 + int'(p_hw) * 4) begin
        r.status = pfc_pkg::ST_BAD;
      end else begin
        if ((p_src & sub_mask) != sub_base) p_src = '0;
        if ((p_dst & sub_mask) != sub_base) p_dst = '0;
        ok = 1;
      end
    end else if (p_et == pfc_pkg::ET_IPV6) begin
      if (cnt < l3 + 40) r.status = pfc_pkg::ST_BAD;
      else begin
        p_src = '0;
        p_dst = '0;
        ok = 1;
      end
    end else begin
      r.ether_type = p_et;
    end
    if (ok) begin
      found = 0;
      r.ether_type = p_et;
      r.source_address = p_src;
      r.dest_address = p_dst;
      r.ip_protocol = p_proto;
      foreach (flows[dir][k]) begin
        if (!found && flows[dir][k].addrs == {p_src, p_dst} &&
            flows[dir][k].prot == {p_et, p_proto}) begin
          flows[dir][k].pk += 64'd1;
          flows[dir][k].by += 64'(flen);
          r.packet_count = flows[dir][k].pk;
          r.byte_count = flows[dir][k].by;
          r.status = pfc_pkg::ST_EXIST;
          found = 1;
        end
      end
      if (!found) begin
        if (flows[dir].size() < pfc_pkg::TABLE_ENTRIES) begin
          f = '{{p_src, p_dst}, {p_et, p_proto}, 64'd1, 64'(flen)};
          flows[dir].push_back(f);
          r.status = pfc_pkg::ST_NEW;
          r.packet_count = 64'd1;
          r.byte_count = 64'(flen);
        end else begin
          r.status = pfc_pkg::ST_FULL;
        end
      end
    end
    expected_results.push_back(r);
    clear_parser();
  endtask

  task automatic send_byte(logic [7:0] b, logic last, logic [15:0] flen, logic dir);
    if (idle_on && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    in_ch.frame_length <= flen;
    in_ch.direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    count_flow_byte(b, last, flen, dir);
  endtask

  // tag: 0 none, 1 802.1Q, 2 802.1ad
  task automatic build_frame(int tag, logic [15:0] et, logic [3:0] ihl, logic [7:0] proto,
                             logic [31:0] s, logic [31:0] d, int cap_len);
    int l3;
    int o;
    logic [7:0] b;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (tag != 0) begin
      frame_bytes.push_back(tag == 1 ? pfc_pkg::ET_VLAN_Q[15:8] : pfc_pkg::ET_VLAN_AD[15:8]);
      frame_bytes.push_back(tag == 1 ? pfc_pkg::ET_VLAN_Q[7:0] : pfc_pkg::ET_VLAN_AD[7:0]);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(et[15:8]);
    frame_bytes.push_back(et[7:0]);
    l3 = frame_bytes.size();
    while (frame_bytes.size() < cap_len) begin
      o = frame_bytes.size() - l3;
      b = 8'($urandom);
      if (et == pfc_pkg::ET_IPV4) begin
        if (o == 0) b = {4'h4, ihl};
        else if (o == 9) b = proto;
        else if (o >= 12 && o <= 15) b = s[8*(15-o) +: 8];
        else if (o >= 16 && o <= 19) b = d[8*(19-o) +: 8];
      end else if (et == pfc_pkg::ET_IPV6 && o == 6) begin
        b = proto;
      end
      frame_bytes.push_back(b);
    end
    while (frame_bytes.size() > cap_len) void'(frame_bytes.pop_back());
  endtask

  task automatic send_frame(logic [15:0] flen, logic dir);
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(frame_bytes[i], i == n - 1, i == n - 1 ? flen : 16'($urandom),
                i == n - 1 ? dir : 1'($urandom));
    frames_sent++;
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(3))
      0: return sub_base | 32'($urandom_range(3));
      1: return addr_pool[$urandom_range(5)];
      2: return $urandom;
      default: return sub_base | ($urandom & ~sub_mask);
    endcase
  endfunction

  task automatic random_frame();
    int kind;
    int tag;
    logic [3:0] ihl;
    logic [15:0] et;
    int len;
    kind = $urandom_range(99);
    tag = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    if (kind < 60) begin
      et = pfc_pkg::ET_IPV4;
      len = 14 + 4 * tag + int'(ihl) * 4 + $urandom_range(0, 30);
    end else if (kind < 80) begin
      et = pfc_pkg::ET_IPV6;
      len = 14 + 4 * tag + 40 + $urandom_range(0, 30);
    end else begin
      et = ($urandom_range(1) == 0) ? pfc_pkg::ET_IPV4 : 16'($urandom);
      ihl = 4'($urandom);
      len = $urandom_range(1, 140);
    end
    build_frame(tag, et, ihl, 8'($urandom_range(2) == 0 ? $urandom : 6 + 11 * $urandom_range(1)),
                pick_addr(), pick_addr(), len);
    send_frame(16'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pfc_pkg::REG_MASK) sub_mask = val;
    else sub_base = val;
  endtask

  task automatic set_subnet(logic [31:0] m, logic [31:0] b);
    wait_idle();
    write_reg(pfc_pkg::REG_MASK, m);
    write_reg(pfc_pkg::REG_BASE, b);
  endtask

  task automatic test_directed();
    logic [31:0] a;
    logic [31:0] c;
    a = addr_pool[0];
    c = addr_pool[1];
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 34);
    send_frame(16'd0, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 60);
    send_frame(16'hFFFF, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 60);
    send_frame(16'hFFFF, 1'b1);
    build_frame(1, pfc_pkg::ET_IPV4, 4'd5, 8'd17, c, a, 38);
    send_frame(16'd64, 1'b0);
    build_frame(2, pfc_pkg::ET_IPV4, 4'd15, 8'd255, a, a, 18 + 60);
    send_frame(16'd1500, 1'b1);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd0, 32'hFFFFFFFF, 32'h00000000, 34);
    send_frame(16'd100, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV6, 4'd0, 8'd58, a, c, 54);
    send_frame(16'd90, 1'b0);
    build_frame(1, pfc_pkg::ET_IPV6, 4'd0, 8'd6, a, c, 57);
    send_frame(16'd90, 1'b1);
    build_frame(0, 16'h0806, 4'd0, 8'd0, a, c, 42);
    send_frame(16'd42, 1'b0);
    build_frame(1, pfc_pkg::ET_VLAN_Q, 4'd0, 8'd0, a, c, 40);
    send_frame(16'd42, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 13);
    send_frame(16'd13, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 1);
    send_frame(16'd1, 1'b1);
    build_frame(1, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 16);
    send_frame(16'd16, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd4, 8'd6, a, c, 40);
    send_frame(16'd40, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd0, 8'd6, a, c, 40);
    send_frame(16'd40, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd15, 8'd6, a, c, 50);
    send_frame(16'd50, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 33);
    send_frame(16'd33, 1'b0);
    build_frame(0, pfc_pkg::ET_IPV6, 4'd0, 8'd17, a, c, 53);
    send_frame(16'd53, 1'b1);
    build_frame(0, pfc_pkg::ET_IPV4, 4'd5, 8'd6, a, c, 140);
    send_frame(16'd140, 1'b0);
    build_frame(2, pfc_pkg::ET_IPV6, 4'd0, 8'd17, a, c, 140);
    send_frame(16'd9000, 1'b1);
  endtask

  task automatic test_subnet_config();
    set_subnet(32'h00000000, 32'h00000000);
    repeat (2) random_frame();
    set_subnet(32'hFFFFFFFF, addr_pool[2]);
    repeat (2) random_frame();
    set_subnet(32'h00000000, 32'h00000001);
    repeat (2) random_frame();
    set_subnet(32'hFFFFFF00, $urandom & 32'hFFFFFF00);
    repeat (2) random_frame();
    set_subnet(pfc_pkg::MASK_RESET, pfc_pkg::BASE_RESET);
  endtask

  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      idle_on = !((bytes_sent - start) > RANDOM_ITEMS / 4 &&
                  (bytes_sent - start) < 3 * RANDOM_ITEMS / 4);
      random_frame();
    end
    idle_on = 1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1;
    repeat (3) random_frame();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d", out_ch.status));
      end else begin
        want = expected_results.pop_front();
        check("status", 64'(out_ch.status), 64'(want.status));
        check("ether_type", 64'(out_ch.ether_type), 64'(want.ether_type));
        check("source_address", 64'(out_ch.source_address), 64'(want.source_address));
        check("dest_address", 64'(out_ch.dest_address), 64'(want.dest_address));
        check("ip_protocol", 64'(out_ch.ip_protocol), 64'(want.ip_protocol));
        check("packet_count", out_ch.packet_count, want.packet_count);
        check("byte_count", out_ch.byte_count, want.byte_count);
        if (int'(want.status) < 5) status_seen[int'(want.status)]++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || finished || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.frame_length = '0;
    in_ch.direction = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pfc_pkg::REG_MASK;
    cfg_data = '0;
    rst = 1'b1;
    idle_on = 1;
    hold_req = 0;
    hold_left = 0;
    finished = 0;
    sub_mask = pfc_pkg::MASK_RESET;
    sub_base = pfc_pkg::BASE_RESET;
    clear_parser();
    foreach (addr_pool[i]) addr_pool[i] = pfc_pkg::BASE_RESET | 32'($urandom_range(16'hFFFF));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_subnet_config();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    finished = 1;
    $display("%0d bytes in %0d frames, %0d results checked, %0d errors", bytes_sent,
             frames_sent, results_seen, errors);
    $display("existing %0d, new %0d, full %0d, not ip %0d, bad header %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
